// ----- hdl/nearest_neighbor_scaler_rgb565_to_bgr222_top_macros.svh -----
// Assertion macros shared by the scaler's top level.
`ifndef NEAREST_NEIGHBOR_SCALER_RGB565_TO_BGR222_TOP_MACROS_SVH
`define NEAREST_NEIGHBOR_SCALER_RGB565_TO_BGR222_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Condition in the same cycle implies the consequent.
`define NNS_ASSERT_SAME(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("scaler assertion failed");
// Condition implies the consequent in the next cycle.
`define NNS_ASSERT_NEXT(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("scaler assertion failed");
`else
`define NNS_ASSERT_SAME(label, cond, cons)
`define NNS_ASSERT_NEXT(label, cond, cons)
`endif
`endif

// ----- hdl/nns_pkg.sv -----
// Shared types and constants of the nearest-neighbor scaler.
package nns_pkg;

   // Field and internal widths fixed by the item format.
   localparam int WIDTH_W  = 9;
   localparam int HEIGHT_W = 8;
   localparam int PIXEL_W  = 16;
   localparam int DX_W     = 8;
   localparam int DY_W     = 7;
   localparam int COLOR_W  = 6;
   localparam int SCALE_W  = 17;
   localparam int COL_W    = 17;
   localparam int ROW_W    = 16;
   localparam int COUNT_W  = 17;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   // Reset geometry.
   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 9'd160;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 8'd120;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

   // Item operations.
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // Geometry and scale factors derived from the configuration.
   typedef struct packed {
      logic [WIDTH_W-1:0]  width;
      logic [HEIGHT_W-1:0] height;
      logic [SCALE_W-1:0]  sx;
      logic [SCALE_W-1:0]  sy;
      logic [COUNT_W-1:0]  total;
      logic                ok;
      logic                busy;
   } geom_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      op_type              op;
      logic                frame_start;
      logic [COLOR_W-1:0]  color;
      logic                pre_ok;
      logic [COUNT_W-1:0]  idx;
   } cmd_type;

endpackage

// ----- hdl/nns_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module nns_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 76800,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/nns_scale.sv -----
// Configuration registers and the 9.8 scale factors, found by reciprocal multiplication.
module nns_scale #(
   parameter int MAX_SRC_WIDTH  = 320,
   parameter int MAX_SRC_HEIGHT = 240,
   parameter int DST_WIDTH      = 160,
   parameter int DST_HEIGHT     = 120
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [nns_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nns_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output nns_pkg::geom_type                 geom
);

   // A divide by the destination size is a multiply by its reciprocal rounded up.
   // Shifting by the numerator width plus the divisor's bit length keeps the
   // quotient exact for every numerator below 2**SCALE_W.
   localparam int SHIFT_X  = nns_pkg::SCALE_W + $clog2(DST_WIDTH);
   localparam int SHIFT_Y  = nns_pkg::SCALE_W + $clog2(DST_HEIGHT);
   localparam int RECIP_W  = nns_pkg::SCALE_W + 1;
   localparam int PROD_X_W = SHIFT_X + nns_pkg::SCALE_W + 1;
   localparam int PROD_Y_W = SHIFT_Y + nns_pkg::SCALE_W + 1;
   localparam logic [RECIP_W-1:0] RECIP_X =
      RECIP_W'(((64'd1 << SHIFT_X) + 64'(DST_WIDTH) - 64'd1) / 64'(DST_WIDTH));
   localparam logic [RECIP_W-1:0] RECIP_Y =
      RECIP_W'(((64'd1 << SHIFT_Y) + 64'(DST_HEIGHT) - 64'd1) / 64'(DST_HEIGHT));
   localparam logic [10:0] MAX_W_L = 11'(MAX_SRC_WIDTH);
   localparam logic [10:0] MAX_H_L = 11'(MAX_SRC_HEIGHT);

   logic [nns_pkg::WIDTH_W-1:0]  width_ff, width_in;
   logic [nns_pkg::HEIGHT_W-1:0] height_ff, height_in;
   logic [nns_pkg::COUNT_W-1:0]  total_ff, total_in;
   logic                         ok_ff, ok_in;
   logic                         start_ff, start_in;
   logic [nns_pkg::SCALE_W-1:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic [nns_pkg::SCALE_W-1:0]  num_x, num_y;
   logic [PROD_X_W-1:0]          prod_x;
   logic [PROD_Y_W-1:0]          prod_y;

   // Register writes; each write leaves the scale factors stale until they are recomputed.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      start_in  = 1'b0;
      if (csr_write_enable) begin
         start_in = 1'b1;
         unique case (csr_index)
            nns_pkg::REG_SRC_WIDTH: begin
               width_in = csr_write_data;
            end
            nns_pkg::REG_SRC_HEIGHT: begin
               height_in = csr_write_data[nns_pkg::HEIGHT_W-1:0];
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   // Frame size and geometry check, registered.
   assign total_in = nns_pkg::COUNT_W'(width_ff) * nns_pkg::COUNT_W'(height_ff);
   assign ok_in = (width_ff != '0) && ({2'b00, width_ff} <= MAX_W_L) &&
                  (height_ff != '0) && ({3'b000, height_ff} <= MAX_H_L);

   // Scale factors: source size times 256, divided by the destination size.
   assign num_x  = {width_ff, 8'h00};
   assign num_y  = {1'b0, height_ff, 8'h00};
   assign prod_x = PROD_X_W'(num_x) * PROD_X_W'(RECIP_X);
   assign prod_y = PROD_Y_W'(num_y) * PROD_Y_W'(RECIP_Y);
   assign sx_in  = prod_x[SHIFT_X +: nns_pkg::SCALE_W];
   assign sy_in  = prod_y[SHIFT_Y +: nns_pkg::SCALE_W];

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= nns_pkg::RESET_WIDTH;
         height_ff <= nns_pkg::RESET_HEIGHT;
         start_ff  <= 1'b1;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         start_ff  <= start_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      total_ff <= total_in;
      ok_ff    <= ok_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
   end

   assign geom.width  = width_ff;
   assign geom.height = height_ff;
   assign geom.sx     = sx_ff;
   assign geom.sy     = sy_ff;
   assign geom.total  = total_ff;
   assign geom.ok     = ok_ff;
   assign geom.busy   = start_ff;

endmodule

// ----- hdl/nns_queue.sv -----
// Short queue of classified items between the front and the back.
module nns_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nns_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output nns_pkg::cmd_type  head_cmd,
   output logic              full,
   output logic              empty
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W:0] DEPTH_L = (PTR_W + 1)'(DEPTH);

   nns_pkg::cmd_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == DEPTH_L);
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/nns_front.sv -----
// Front end: accepts items, converts colors and maps read coordinates to a raster index.
module nns_front #(
   parameter int DST_WIDTH  = 160,
   parameter int DST_HEIGHT = 120
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic                           req_frame_start,
   input  logic [nns_pkg::PIXEL_W-1:0]    req_pixel_rgb565,
   input  logic [nns_pkg::DX_W-1:0]       req_dest_x,
   input  logic [nns_pkg::DY_W-1:0]       req_dest_y,
   input  nns_pkg::geom_type              geom,
   input  logic                           q_full,
   output logic                           push,
   output nns_pkg::cmd_type               push_cmd
);

   localparam logic [9:0] DST_W_L = 10'(DST_WIDTH);
   localparam logic [8:0] DST_H_L = 9'(DST_HEIGHT);
   localparam int PX_W = nns_pkg::DX_W + nns_pkg::SCALE_W;
   localparam int PY_W = nns_pkg::DY_W + nns_pkg::SCALE_W;

   logic                         advance;
   logic                         accept;
   logic [PX_W-1:0]              prod_x;
   logic [PY_W-1:0]              prod_y;

   // Stage 1: mapped column and row.
   logic                         s1_valid_ff, s1_valid_in;
   nns_pkg::op_type              s1_op_ff;
   logic                         s1_fs_ff;
   logic [nns_pkg::COLOR_W-1:0]  s1_color_ff;
   logic                         s1_ok_ff;
   logic [nns_pkg::COL_W-1:0]    s1_col_ff;
   logic [nns_pkg::ROW_W-1:0]    s1_row_ff;

   // Stage 2: raster index and range check.
   logic                         s2_valid_ff, s2_valid_in;
   nns_pkg::cmd_type             s2_cmd_ff, s2_cmd_in;

   // RGB565 to 2-2-2 blue/green/red: top two bits of each channel.
   function automatic logic [nns_pkg::COLOR_W-1:0] to_bgr222(
      input logic [nns_pkg::PIXEL_W-1:0] pix
   );
      return {pix[4:3], pix[10:9], pix[15:14]};
   endfunction

   // The whole front moves together unless its last item cannot enter the queue.
   assign advance   = !s2_valid_ff || !q_full;
   assign req_stall = !advance || geom.busy;
   assign accept    = req_valid && !req_stall;
   assign push      = s2_valid_ff && !q_full;
   assign push_cmd  = s2_cmd_ff;

   assign prod_x = PX_W'(req_dest_x) * PX_W'(geom.sx);
   assign prod_y = PY_W'(req_dest_y) * PY_W'(geom.sy);

   assign s1_valid_in = advance ? accept : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   // Index of the source pixel and the bounds check against the source size.
   always_comb begin
      s2_cmd_in.op          = s1_op_ff;
      s2_cmd_in.frame_start = s1_fs_ff;
      s2_cmd_in.color       = s1_color_ff;
      s2_cmd_in.pre_ok      = s1_ok_ff &&
                              (s1_col_ff < nns_pkg::COL_W'(geom.width)) &&
                              (s1_row_ff < nns_pkg::ROW_W'(geom.height));
      s2_cmd_in.idx         = nns_pkg::COUNT_W'(s1_row_ff[nns_pkg::HEIGHT_W-1:0]) *
                              nns_pkg::COUNT_W'(geom.width) +
                              nns_pkg::COUNT_W'(s1_col_ff[nns_pkg::WIDTH_W-1:0]);
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff    <= nns_pkg::op_type'(req_operation);
         s1_fs_ff    <= req_frame_start;
         s1_color_ff <= to_bgr222(req_pixel_rgb565);
         s1_ok_ff    <= geom.ok && ({2'b00, req_dest_x} < DST_W_L) &&
                        ({2'b00, req_dest_y} < DST_H_L);
         s1_col_ff   <= prod_x[PX_W-1:8];
         s1_row_ff   <= prod_y[PY_W-1:8];
         s2_cmd_ff   <= s2_cmd_in;
      end
   end

endmodule

// ----- hdl/nns_back.sv -----
// Back end: writes loaded pixels to the frame store and answers reads.
module nns_back #(
   parameter int MAX_SRC_WIDTH  = 320,
   parameter int MAX_SRC_HEIGHT = 240
) (
   input  logic                           clock,
   input  logic                           reset,
   input  nns_pkg::geom_type              geom,
   input  nns_pkg::cmd_type               head_cmd,
   input  logic                           q_empty,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [nns_pkg::COLOR_W-1:0]    rsp_dest_color,
   output logic                           rsp_sample_loaded
);

   localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [nns_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [nns_pkg::COUNT_W-1:0]  base;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         hit_ff, hit_in;
   logic                         is_load;
   logic                         do_write;
   logic                         do_read;
   logic                         out_free;
   logic [nns_pkg::COLOR_W-1:0]  rd_data;

   // Loads never wait on the result side; reads need a free output register.
   assign is_load  = (head_cmd.op == nns_pkg::OP_LOAD);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = !q_empty && (is_load || out_free);
   assign do_read  = pop && !is_load;

   // Write position: restart on frame start, stop once the frame is full.
   assign base     = head_cmd.frame_start ? '0 : count_ff;
   assign do_write = pop && is_load && geom.ok && (base < geom.total);

   always_comb begin
      count_in = count_ff;
      if (pop && is_load) begin
         count_in = do_write ? base + 1'b1 : base;
      end
   end

   // A read hits only pixels already loaded in this frame.
   assign hit_in = head_cmd.pre_ok && (head_cmd.idx < count_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (do_read) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_read) begin
         hit_ff <= hit_in;
      end
   end

   // Frame store.
   nns_ram #(
      .WIDTH (nns_pkg::COLOR_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (ADDR_W'(base)),
      .wr_data (head_cmd.color),
      .rd_en   (do_read),
      .rd_addr (ADDR_W'(head_cmd.idx)),
      .rd_data (rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_loaded = hit_ff;
   assign rsp_dest_color    = hit_ff ? rd_data : '0;

endmodule

// ----- hdl/nearest_neighbor_scaler_rgb565_to_bgr222_top.sv -----
// A read item passes front stages 1 and 2, a queue entry and then the output register.
// One item per cycle when nothing stalls; a four-entry queue splits front and back.
// Loads produce no result; reads produce one result each, in order.
// After reset and after every register write the input stalls for one cycle while the
// scale factors are registered again; the frame store needs no clearing.
// Reset is synchronous and active high and empties the frame (write position zero).
`include "nearest_neighbor_scaler_rgb565_to_bgr222_top_macros.svh"

module nearest_neighbor_scaler_rgb565_to_bgr222_top #(
   parameter int MAX_SRC_WIDTH  = 320,
   parameter int MAX_SRC_HEIGHT = 240,
   parameter int DST_WIDTH      = 160,
   parameter int DST_HEIGHT     = 120
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic                           req_frame_start,
   input  logic [nns_pkg::PIXEL_W-1:0]    req_pixel_rgb565,
   input  logic [nns_pkg::DX_W-1:0]       req_dest_x,
   input  logic [nns_pkg::DY_W-1:0]       req_dest_y,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [nns_pkg::COLOR_W-1:0]    rsp_dest_color,
   output logic                           rsp_sample_loaded,
   input  logic                           csr_write_enable,
   input  logic [nns_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nns_pkg::CSR_DATA_W-1:0] csr_write_data
);

   nns_pkg::geom_type geom;
   nns_pkg::cmd_type  push_cmd;
   nns_pkg::cmd_type  head_cmd;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_empty;

   // Configuration and scale factors.
   nns_scale #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .DST_WIDTH      (DST_WIDTH),
      .DST_HEIGHT     (DST_HEIGHT)
   ) u_scale (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .geom             (geom)
   );

   // Item intake and address mapping.
   nns_front #(
      .DST_WIDTH  (DST_WIDTH),
      .DST_HEIGHT (DST_HEIGHT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_frame_start  (req_frame_start),
      .req_pixel_rgb565 (req_pixel_rgb565),
      .req_dest_x       (req_dest_x),
      .req_dest_y       (req_dest_y),
      .geom             (geom),
      .q_full           (q_full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   // Decoupling queue.
   nns_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   // Frame store access and result output.
   nns_back #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .geom              (geom),
      .head_cmd          (head_cmd),
      .q_empty           (q_empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dest_color    (rsp_dest_color),
      .rsp_sample_loaded (rsp_sample_loaded)
   );

   // A result without a loaded sample always carries color zero.
   `NNS_ASSERT_SAME(a_unloaded_is_zero, rsp_valid && !rsp_sample_loaded, rsp_dest_color == '0)
   // A register write holds off new items while the scale factors are recomputed.
   `NNS_ASSERT_NEXT(a_csr_write_stalls, csr_write_enable, req_stall)
   // The scale factors are refreshed right after reset, so no item enters then.
   `NNS_ASSERT_SAME(a_stall_after_reset, $fell(reset), req_stall)
   // The queue never reports full and empty at once.
   `NNS_ASSERT_SAME(a_queue_sane, q_full, !q_empty)

endmodule

// ----- tb/tb_nearest_neighbor_scaler_rgb565_to_bgr222_top.sv -----
// Self-checking testbench for the nearest-neighbor RGB565 to BGR222 scaler top level.
module tb_nearest_neighbor_scaler_rgb565_to_bgr222_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W         = 320;
   localparam int MAX_H         = 240;
   localparam int DST_W         = 160;
   localparam int DST_H         = 120;
   localparam int STORE_DEPTH   = MAX_W * MAX_H;
   localparam int RANDOM_ITEMS  = 2000;
   // Covers the scale update and the read pipeline, with margin.
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int END_WAIT      = 2000;
   localparam int MAX_REPORTS   = 40;

   // One predicted or observed read result.
   typedef struct packed {
      logic [nns_pkg::COLOR_W-1:0] color;
      logic                        loaded;
   } pixel_result_type;

   logic                           clock             = 1'b0;
   logic                           reset             = 1'b1;
   logic                           req_valid         = 1'b0;
   logic                           req_stall;
   logic                           req_operation     = nns_pkg::OP_LOAD;
   logic                           req_frame_start   = 1'b0;
   logic [nns_pkg::PIXEL_W-1:0]    req_pixel_rgb565  = '0;
   logic [nns_pkg::DX_W-1:0]       req_dest_x        = '0;
   logic [nns_pkg::DY_W-1:0]       req_dest_y        = '0;
   logic                           rsp_valid;
   logic                           rsp_stall         = 1'b0;
   logic [nns_pkg::COLOR_W-1:0]    rsp_dest_color;
   logic                           rsp_sample_loaded;
   logic                           csr_write_enable  = 1'b0;
   logic [nns_pkg::CSR_IDX_W-1:0]  csr_index         = nns_pkg::REG_SRC_WIDTH;
   logic [nns_pkg::CSR_DATA_W-1:0] csr_write_data    = '0;

   // Shadow copy of the block's configuration and frame.
   logic [nns_pkg::WIDTH_W-1:0]    cfg_width  = nns_pkg::RESET_WIDTH;
   logic [nns_pkg::HEIGHT_W-1:0]   cfg_height = nns_pkg::RESET_HEIGHT;
   logic [nns_pkg::COLOR_W-1:0]    shadow_store [0:STORE_DEPTH-1];
   int unsigned                    shadow_count = 0;

   // Reads accepted but not yet answered, oldest first.
   pixel_result_type               expected_samples [$];
   pixel_result_type               oldest_sample;

   bit                    tx_idle_on = 1'b1;
   bit                    rx_idle_on = 1'b1;
   int                    stall_left = 0;
   int                    cycle_count = 0;
   int                    error_count = 0;
   int                    items_counted = 0;
   int                    loads_sent = 0;
   int                    reads_sent = 0;
   int                    results_checked = 0;
   int                    loaded_hits = 0;
   int                    settings_written = 0;

   nearest_neighbor_scaler_rgb565_to_bgr222_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_frame_start   (req_frame_start),
      .req_pixel_rgb565  (req_pixel_rgb565),
      .req_dest_x        (req_dest_x),
      .req_dest_y        (req_dest_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dest_color    (rsp_dest_color),
      .rsp_sample_loaded (rsp_sample_loaded),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // Free-running clock.
   always #5ns clock = ~clock;

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(string what, int want, int got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR cycle %0d: %s: expected %0d, got %0d", cycle_count, what, want, got);
   endtask

   function automatic bit geometry_valid();
      return cfg_width >= 1 && cfg_width <= MAX_W && cfg_height >= 1 && cfg_height <= MAX_H;
   endfunction

   // Keeps the top two bits of each channel: blue, green, red from high to low.
   function automatic logic [nns_pkg::COLOR_W-1:0] to_bgr222(
      logic [nns_pkg::PIXEL_W-1:0] pix
   );
      return {pix[4:3], pix[10:9], pix[15:14]};
   endfunction

   // Applies one load to the shadow frame; returns 0 when the block ignores it.
   function automatic bit store_pixel(bit fs, logic [nns_pkg::PIXEL_W-1:0] pix);
      int unsigned frame_size;
      frame_size = int'(cfg_width) * int'(cfg_height);
      if (fs)
         shadow_count = 0;
      if (!geometry_valid() || shadow_count >= frame_size || shadow_count >= STORE_DEPTH)
         return fs;
      shadow_store[shadow_count] = to_bgr222(pix);
      shadow_count++;
      return 1'b1;
   endfunction

   // Maps a destination pixel to its source pixel through the 9.8 scale factors.
   function automatic pixel_result_type scaled_sample(logic [nns_pkg::DX_W-1:0] dx,
                                                      logic [nns_pkg::DY_W-1:0] dy);
      pixel_result_type res;
      int unsigned      sx;
      int unsigned      sy;
      int unsigned      col;
      int unsigned      row;
      int unsigned      idx;
      res = '0;
      if (geometry_valid() && dx < DST_W && dy < DST_H) begin
         sx  = (int'(cfg_width) << 8) / DST_W;
         sy  = (int'(cfg_height) << 8) / DST_H;
         col = (int'(dx) * sx) >> 8;
         row = (int'(dy) * sy) >> 8;
         if (col < cfg_width && row < cfg_height) begin
            idx = row * int'(cfg_width) + col;
            if (idx < shadow_count && idx < STORE_DEPTH) begin
               res.color  = shadow_store[idx];
               res.loaded = 1'b1;
            end
         end
      end
      return res;
   endfunction

   // Sends one item, waits for its acceptance and records the prediction.
   // Valid stays high on return so that a following item can go out back to back.
   task automatic send_item(nns_pkg::op_type op, bit fs, logic [nns_pkg::PIXEL_W-1:0] pix,
                            logic [nns_pkg::DX_W-1:0] dx, logic [nns_pkg::DY_W-1:0] dy);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_frame_start  <= fs;
      req_pixel_rgb565 <= pix;
      req_dest_x       <= dx;
      req_dest_y       <= dy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == nns_pkg::OP_READ) begin
         expected_samples.push_back(scaled_sample(dx, dy));
         reads_sent++;
         items_counted++;
      end else begin
         loads_sent++;
         if (store_pixel(fs, pix))
            items_counted++;
      end
   endtask

   // Read with mostly in-range coordinates, biased toward the top rows.
   task automatic send_random_read();
      logic [nns_pkg::DX_W-1:0] dx;
      logic [nns_pkg::DY_W-1:0] dy;
      if ($urandom_range(0, 9) == 0)
         dx = nns_pkg::DX_W'($urandom);
      else
         dx = nns_pkg::DX_W'($urandom_range(0, DST_W - 1));
      case ($urandom_range(0, 9))
         0: begin
            dy = nns_pkg::DY_W'($urandom);
         end
         1, 2, 3: begin
            dy = nns_pkg::DY_W'($urandom_range(0, 3));
         end
         default: begin
            dy = nns_pkg::DY_W'($urandom_range(0, DST_H - 1));
         end
      endcase
      send_item(nns_pkg::OP_READ, 1'($urandom_range(0, 1)), nns_pkg::PIXEL_W'($urandom),
                dx, dy);
   endtask

   // Stops sending and lets every expected result and any load in flight finish.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write, then time for the scale factors to settle.
   task automatic write_reg(logic [nns_pkg::CSR_IDX_W-1:0] index,
                            logic [nns_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == nns_pkg::REG_SRC_WIDTH)
         cfg_width = data[nns_pkg::WIDTH_W-1:0];
      else
         cfg_height = data[nns_pkg::HEIGHT_W-1:0];
      settings_written++;
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(logic [nns_pkg::CSR_DATA_W-1:0] w,
                               logic [nns_pkg::CSR_DATA_W-1:0] h);
      wait_for_drain();
      write_reg(nns_pkg::REG_SRC_WIDTH, w);
      write_reg(nns_pkg::REG_SRC_HEIGHT, h);
   endtask

   // Loads a frame with reads mixed in, then samples it with a few more reads.
   task automatic run_frame(logic [nns_pkg::CSR_DATA_W-1:0] w,
                            logic [nns_pkg::CSR_DATA_W-1:0] h,
                            bit restart, int unsigned load_budget);
      int unsigned loads_left;
      bit          first;
      set_geometry(w, h);
      loads_left = load_budget;
      first      = restart;
      while (loads_left > 0) begin
         if ($urandom_range(0, 99) < 35) begin
            send_random_read();
         end else begin
            // A stray frame start now and then breaks the raster sequence.
            send_item(nns_pkg::OP_LOAD, first || ($urandom_range(0, 59) == 0),
                      nns_pkg::PIXEL_W'($urandom), nns_pkg::DX_W'($urandom),
                      nns_pkg::DY_W'($urandom));
            first = 1'b0;
            loads_left--;
         end
         // Occasionally hold off mid-frame until every read has been answered.
         if ($urandom_range(0, 299) == 0)
            wait_for_drain();
      end
      repeat ($urandom_range(4, 12)) send_random_read();
   endtask

   // Reset geometry: channel extremes, out-of-range reads, frame start on a read.
   task automatic test_reset_geometry();
      wait_for_drain();
      send_item(nns_pkg::OP_LOAD, 1'b1, 16'hFFFF, '0, '0);
      send_item(nns_pkg::OP_LOAD, 1'b0, 16'h0000, 8'hFF, 7'h7F);
      send_item(nns_pkg::OP_LOAD, 1'b0, 16'hA5C3, '0, '0);
      send_item(nns_pkg::OP_READ, 1'b0, 16'hFFFF, 8'd0, 7'd0);
      send_item(nns_pkg::OP_READ, 1'b1, 16'h0000, 8'd1, 7'd0);
      send_item(nns_pkg::OP_READ, 1'b0, 16'h0000, 8'd2, 7'd0);
      send_item(nns_pkg::OP_READ, 1'b0, 16'h0000, 8'd159, 7'd119);
      send_item(nns_pkg::OP_READ, 1'b0, 16'h0000, 8'd160, 7'd0);
      send_item(nns_pkg::OP_READ, 1'b0, 16'h0000, 8'd0, 7'd120);
      send_item(nns_pkg::OP_READ, 1'b0, 16'h0000, 8'hFF, 7'h7F);
   endtask

   // A tiny frame with one pixel more than it holds.
   task automatic test_extra_pixels();
      set_geometry(9'd2, 9'd1);
      send_item(nns_pkg::OP_LOAD, 1'b1, 16'hF800, '0, '0);
      send_item(nns_pkg::OP_LOAD, 1'b0, 16'h07E0, '0, '0);
      send_item(nns_pkg::OP_LOAD, 1'b0, 16'h001F, '0, '0);
      send_item(nns_pkg::OP_READ, 1'b0, '0, 8'd0, 7'd0);
      send_item(nns_pkg::OP_READ, 1'b0, '0, 8'd159, 7'd0);
   endtask

   // New geometry over pixels already stored, without a frame start.
   task automatic test_geometry_change();
      set_geometry(9'd1, 9'd2);
      send_item(nns_pkg::OP_READ, 1'b0, '0, 8'd0, 7'd0);
      send_item(nns_pkg::OP_READ, 1'b0, '0, 8'd0, 7'd119);
      send_item(nns_pkg::OP_LOAD, 1'b0, 16'hFFFF, '0, '0);
   endtask

   // Zero and over-range width and height.
   task automatic test_invalid_geometry();
      set_geometry(9'd0, 9'd120);
      send_item(nns_pkg::OP_LOAD, 1'b1, 16'hFFFF, '0, '0);
      send_item(nns_pkg::OP_READ, 1'b0, '0, 8'd0, 7'd0);
      set_geometry(9'd511, 9'd0);
      send_item(nns_pkg::OP_READ, 1'b0, '0, 8'd0, 7'd0);
      set_geometry(9'd320, 9'd241);
      send_item(nns_pkg::OP_READ, 1'b0, '0, 8'd0, 7'd0);
   endtask

   // Largest source image, partly loaded.
   task automatic test_max_geometry();
      set_geometry(nns_pkg::CSR_DATA_W'(MAX_W), nns_pkg::CSR_DATA_W'(MAX_H));
      send_item(nns_pkg::OP_LOAD, 1'b1, 16'h5555, '0, '0);
      send_item(nns_pkg::OP_LOAD, 1'b0, 16'hAAAA, '0, '0);
      send_item(nns_pkg::OP_LOAD, 1'b0, 16'hC618, '0, '0);
      send_item(nns_pkg::OP_READ, 1'b0, '0, 8'd0, 7'd0);
      send_item(nns_pkg::OP_READ, 1'b0, '0, 8'd1, 7'd0);
      send_item(nns_pkg::OP_READ, 1'b0, '0, 8'd2, 7'd0);
   endtask

   // Random frames over many geometries, mostly small, with the extremes mixed in.
   task automatic test_random_frames();
      int unsigned                    pick;
      int unsigned                    frame;
      int unsigned                    budget;
      int                             start;
      logic [nns_pkg::CSR_DATA_W-1:0] w;
      logic [nns_pkg::CSR_DATA_W-1:0] h;
      bit                             restart;
      start = items_counted;
      while (items_counted - start < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         case (pick)
            0: begin
               w = nns_pkg::CSR_DATA_W'(MAX_W);
               h = nns_pkg::CSR_DATA_W'(MAX_H);
            end
            1: begin
               w = nns_pkg::CSR_DATA_W'(1);
               h = nns_pkg::CSR_DATA_W'(1);
            end
            2: begin
               w = nns_pkg::CSR_DATA_W'(1);
               h = nns_pkg::CSR_DATA_W'(MAX_H);
            end
            3: begin
               w = nns_pkg::CSR_DATA_W'(MAX_W);
               h = nns_pkg::CSR_DATA_W'(1);
            end
            4: begin
               w = $urandom_range(0, 1) ? '0 :
                   nns_pkg::CSR_DATA_W'($urandom_range(MAX_W + 1, 511));
               h = nns_pkg::CSR_DATA_W'($urandom_range(1, MAX_H));
            end
            5: begin
               w = nns_pkg::CSR_DATA_W'($urandom_range(1, MAX_W));
               h = $urandom_range(0, 1) ? '0 :
                   nns_pkg::CSR_DATA_W'($urandom_range(MAX_H + 1, 255));
            end
            default: begin
               w = nns_pkg::CSR_DATA_W'($urandom_range(1, 16));
               h = nns_pkg::CSR_DATA_W'($urandom_range(1, 12));
            end
         endcase
         // The top data bit is not part of the height register.
         if ($urandom_range(0, 7) == 0)
            h[nns_pkg::CSR_DATA_W-1] = 1'b1;
         frame = int'(w) * int'(h[nns_pkg::HEIGHT_W-1:0]);
         if (pick == 4 || pick == 5)
            budget = 8;
         else if (frame <= 120)
            budget = frame + $urandom_range(0, 3);
         else
            budget = $urandom_range(40, 120);
         restart    = $urandom_range(0, 5) != 0;
         tx_idle_on = $urandom_range(0, 3) != 0;
         rx_idle_on = $urandom_range(0, 3) != 0;
         run_frame(w, h, restart, budget);
      end
   endtask

   // Closing frame at full rate on both sides.
   task automatic test_quiet_tail();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      run_frame(9'd12, 9'd10, 1'b1, 124);
   endtask

   // Receiver stalls in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("result with no read waiting", 0, 1);
         end else begin
            oldest_sample = expected_samples.pop_front();
            if (rsp_dest_color !== oldest_sample.color)
               report_mismatch("dest_color", oldest_sample.color, rsp_dest_color);
            if (rsp_sample_loaded !== oldest_sample.loaded)
               report_mismatch("sample_loaded", oldest_sample.loaded, rsp_sample_loaded);
            if (oldest_sample.loaded)
               loaded_hits++;
         end
         results_checked++;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d reads unanswered", cycle_count,
                  expected_samples.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Test sequence.
   initial begin : main_sequence
      int wait_count;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_geometry();
      test_extra_pixels();
      test_geometry_change();
      test_invalid_geometry();
      test_max_geometry();
      test_random_frames();
      test_quiet_tail();

      // Let the last results come back, within a bound.
      req_valid <= 1'b0;
      wait_count = 0;
      while (expected_samples.size() != 0 && wait_count < END_WAIT) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_samples.size() != 0)
         report_mismatch("reads left without a result", 0, expected_samples.size());

      $display("Summary: %0d items sent (%0d loads, %0d reads), %0d register writes.",
               loads_sent + reads_sent, loads_sent, reads_sent, settings_written);
      $display("Summary: %0d results checked, %0d from loaded source pixels, %0d errors.",
               results_checked, loaded_hits, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
